FILE: hw/rtl/particle_integration_step_assert.svh
`ifndef PARTICLE_INTEGRATION_STEP_ASSERT_SVH
`define PARTICLE_INTEGRATION_STEP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PIS_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define PIS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/pis_pkg.sv
package pis_pkg;

	// field widths
	localparam int COMP_W     = 21;
	localparam int NUM_COMP   = 3;
	localparam int VEC_W      = COMP_W * NUM_COMP;
	localparam int DENS_W     = 32;
	localparam int TYPE_W     = 8;
	localparam int DT_W       = 24;
	localparam int VSTEP_W    = DT_W + 1;
	localparam int MODE_W     = 5;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 24;

	// internal arithmetic widths
	localparam int ACC_PROD_W  = COMP_W + VSTEP_W + 1;
	localparam int POS_PROD_W  = COMP_W + DT_W + 1;
	localparam int DENS_PROD_W = DENS_W + VSTEP_W + 1;
	localparam int VEL_SHIFT   = 21;
	localparam int POS_SHIFT   = 20;
	localparam int VSUM_W      = ACC_PROD_W - VEL_SHIFT + 2;
	localparam int NP_W        = POS_PROD_W - POS_SHIFT + 1;
	localparam int DSUM_W      = DENS_PROD_W - VEL_SHIFT + 1;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_MODE_FLAGS = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_LOWER    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_X_UPPER    = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_Y_LOWER    = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_Y_UPPER    = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_Z_LOWER    = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_Z_UPPER    = 4'd7;

	// mode flag bit positions
	localparam int MODE_CONT  = 0;
	localparam int MODE_AVG   = 1;
	localparam int MODE_FIX   = 2;
	localparam int MODE_THREE = 3;
	localparam int MODE_FIRST = 4;

	// reset values
	localparam logic [DT_W-1:0]   DT_RESET = 24'd1049;
	localparam logic [COMP_W-1:0] COMP_MIN = 21'h100000;
	localparam logic [COMP_W-1:0] COMP_MAX = 21'h0FFFFF;

	localparam logic signed [TYPE_W-1:0] NON_EXISTENT_CODE = 8'sd0;

	typedef logic signed [COMP_W-1:0] comp_t;

	// load strobes for the lane pipeline stages
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
	} pis_ld_t;

	// clamp a velocity sum to one component
	function automatic comp_t sat_comp(input logic signed [VSUM_W-1:0] v);
		if (v > $signed({{(VSUM_W-COMP_W){1'b0}}, COMP_MAX}))
			return $signed(COMP_MAX);
		else if (v < $signed({{(VSUM_W-COMP_W){1'b1}}, COMP_MIN}))
			return $signed(COMP_MIN);
		else
			return v[COMP_W-1:0];
	endfunction

	// clamp a density sum to the density width
	function automatic logic signed [DENS_W-1:0] sat_dens(input logic signed [DSUM_W-1:0] v);
		logic signed [DENS_W-1:0] dmax;
		logic signed [DENS_W-1:0] dmin;
		dmax = {1'b0, {(DENS_W-1){1'b1}}};
		dmin = {1'b1, {(DENS_W-1){1'b0}}};
		if (v > DSUM_W'(dmax))
			return dmax;
		else if (v < DSUM_W'(dmin))
			return dmin;
		else
			return v[DENS_W-1:0];
	endfunction

endpackage

FILE: hw/rtl/pis_lane.sv
module pis_lane import pis_pkg::*; (
	input  logic                   clk,
	input  pis_ld_t                ld,
	input  logic [VSTEP_W-1:0]     vstep,
	input  logic [DT_W-1:0]        dt,
	input  logic                   active,
	input  comp_t                  acc,
	input  comp_t                  vel,
	input  comp_t                  corr,
	input  comp_t                  pos,
	output comp_t                  vel_s4,
	output comp_t                  pos_s4,
	output logic signed [NP_W-1:0] np_s4,
	output logic                   active_s4
);

	logic signed [ACC_PROD_W-1:0] acc_prod_s1;
	comp_t                        vel_s1, corr_s1, pos_s1;
	logic                         active_s1;

	comp_t                        vel_s2, pos_s2;
	logic                         active_s2;

	logic signed [POS_PROD_W-1:0] pos_prod_s3;
	comp_t                        vel_s3, pos_s3;
	logic                         active_s3;

	logic signed [ACC_PROD_W-1:0] acc_rnd;
	logic signed [VSUM_W-1:0]     vel_sum;
	logic signed [POS_PROD_W-1:0] pos_rnd;

	// stage 1: acceleration times velocity step
	always_ff @(posedge clk) begin
		if (ld.ld_s1) begin
			acc_prod_s1 <= acc * $signed({1'b0, vstep});
			vel_s1      <= vel;
			corr_s1     <= corr;
			pos_s1      <= pos;
			active_s1   <= active;
		end
	end

	// stage 2: round, add velocity and correction, clamp
	assign acc_rnd = acc_prod_s1 + (ACC_PROD_W'(1) <<< (VEL_SHIFT - 1));
	assign vel_sum = VSUM_W'($signed(acc_rnd[ACC_PROD_W-1:VEL_SHIFT])) + VSUM_W'(vel_s1)
		+ VSUM_W'(corr_s1);

	always_ff @(posedge clk) begin
		if (ld.ld_s2) begin
			vel_s2    <= active_s1 ? sat_comp(vel_sum) : vel_s1;
			pos_s2    <= pos_s1;
			active_s2 <= active_s1;
		end
	end

	// stage 3: new velocity times time step
	always_ff @(posedge clk) begin
		if (ld.ld_s3) begin
			pos_prod_s3 <= vel_s2 * $signed({1'b0, dt});
			vel_s3      <= vel_s2;
			pos_s3      <= pos_s2;
			active_s3   <= active_s2;
		end
	end

	// stage 4: round and add to position, kept exact for the box test
	assign pos_rnd = pos_prod_s3 + (POS_PROD_W'(1) <<< (POS_SHIFT - 1));

	always_ff @(posedge clk) begin
		if (ld.ld_s4) begin
			np_s4     <= NP_W'($signed(pos_rnd[POS_PROD_W-1:POS_SHIFT])) + NP_W'(pos_s3);
			vel_s4    <= vel_s3;
			pos_s4    <= pos_s3;
			active_s4 <= active_s3;
		end
	end

endmodule

FILE: hw/rtl/particle_integration_step.sv
// Leapfrog update of one particle per transaction.
// Input channel (in_valid/in_ready) carries density, density rate, material
// type, packed velocity, acceleration, velocity correction and position, plus
// the last-particle mark; the output channel (out_valid/out_ready) returns the
// updated particle with removed and last_out.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
// mode flags, time step and box bounds; cfg_ready is always high and indexes
// beyond the register list are dropped. Write it only while the pipeline is
// empty.
// Pipeline: five register stages; a particle accepted into stage 1 moves
// through stages 2, 3 and 4 to the stage 5 output register.
// Throughput: one particle per cycle while the output is not stalled, set by
// the five-stage pipeline with the multiplies in stages 1 and 3 (density and
// acceleration products, then the velocity times time step product).
// Reset clears all stage valid bits and loads the register reset values.
// When out_ready is low the output holds; bubbles inside the pipeline still
// fill, and in_ready drops only once every stage holds a particle.
module particle_integration_step import pis_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,

	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [DENS_W-1:0] density,
	input  logic signed [DENS_W-1:0] density_rate,
	input  logic signed [TYPE_W-1:0] material_type,
	input  logic [VEC_W-1:0]         velocity,
	input  logic [VEC_W-1:0]         acceleration,
	input  logic [VEC_W-1:0]         velocity_correction,
	input  logic [VEC_W-1:0]         position,
	input  logic                     last_particle,

	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DENS_W-1:0] new_density,
	output logic signed [TYPE_W-1:0] new_material_type,
	output logic [VEC_W-1:0]         new_velocity,
	output logic [VEC_W-1:0]         new_position,
	output logic                     removed,
	output logic                     last_out
);

	// configuration registers
	logic [MODE_W-1:0] mode_q;
	logic [DT_W-1:0]   dt_q;
	comp_t             lo_q [NUM_COMP];
	comp_t             hi_q [NUM_COMP];

	// pipeline control
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	logic ld_s5;
	pis_ld_t ld;

	logic [VSTEP_W-1:0] vstep;

	// density and side-band path
	logic signed [DENS_PROD_W-1:0] dprod_s1;
	logic signed [DENS_W-1:0]      dens_s1, dens_s2, dens_s3, dens_s4, dens_s5;
	logic signed [TYPE_W-1:0]      type_s1, type_s2, type_s3, type_s4, type_s5;
	logic                          last_s1, last_s2, last_s3, last_s4, last_s5;
	logic                          removed_s5;
	logic [VEC_W-1:0]              vel_s5, pos_s5;
	logic signed [DENS_PROD_W-1:0] drnd;
	logic signed [DSUM_W-1:0]      dsum;

	// lane outputs
	comp_t                  lane_vel [NUM_COMP];
	comp_t                  lane_pos [NUM_COMP];
	logic signed [NP_W-1:0] lane_np  [NUM_COMP];
	logic [NUM_COMP-1:0]    lane_act;
	logic [NUM_COMP-1:0]    lane_in;
	logic                   outside;
	logic                   drop;

	// configuration write transactions
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
			dt_q   <= DT_RESET;
			for (int i = 0; i < NUM_COMP; i++) begin
				lo_q[i] <= $signed(COMP_MIN);
				hi_q[i] <= $signed(COMP_MAX);
			end
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MODE_FLAGS: mode_q  <= cfg_data[MODE_W-1:0];
				REG_TIME_STEP:  dt_q    <= cfg_data[DT_W-1:0];
				REG_X_LOWER:    lo_q[0] <= cfg_data[COMP_W-1:0];
				REG_X_UPPER:    hi_q[0] <= cfg_data[COMP_W-1:0];
				REG_Y_LOWER:    lo_q[1] <= cfg_data[COMP_W-1:0];
				REG_Y_UPPER:    hi_q[1] <= cfg_data[COMP_W-1:0];
				REG_Z_LOWER:    lo_q[2] <= cfg_data[COMP_W-1:0];
				REG_Z_UPPER:    hi_q[2] <= cfg_data[COMP_W-1:0];
				default: ;
			endcase
		end
	end

	// velocity step in Q4.21: half of dt on the first step
	assign vstep = mode_q[MODE_FIRST] ? {1'b0, dt_q} : {dt_q, 1'b0};

	// ready chain and load strobes
	assign rdy_s5   = !vld_s5 || out_ready;
	assign rdy_s4   = !vld_s4 || rdy_s5;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	assign ld.ld_s1 = in_valid && rdy_s1;
	assign ld.ld_s2 = vld_s1 && rdy_s2;
	assign ld.ld_s3 = vld_s2 && rdy_s3;
	assign ld.ld_s4 = vld_s3 && rdy_s4;
	assign ld_s5    = vld_s4 && rdy_s5;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
		end
	end

	// per-component velocity and position lanes
	for (genvar g = 0; g < NUM_COMP; g++) begin : g_lane
		logic lane_active;
		assign lane_active = (material_type > 0) && ((g < NUM_COMP - 1) || mode_q[MODE_THREE]);

		pis_lane u_lane (
			.clk       (clk),
			.ld        (ld),
			.vstep     (vstep),
			.dt        (dt_q),
			.active    (lane_active),
			.acc       (acceleration[g*COMP_W +: COMP_W]),
			.vel       (velocity[g*COMP_W +: COMP_W]),
			.corr      (mode_q[MODE_AVG] ? velocity_correction[g*COMP_W +: COMP_W] : '0),
			.pos       (position[g*COMP_W +: COMP_W]),
			.vel_s4    (lane_vel[g]),
			.pos_s4    (lane_pos[g]),
			.np_s4     (lane_np[g]),
			.active_s4 (lane_act[g])
		);

		// open box test, only for components that moved
		assign lane_in[g] = !lane_act[g] || ((lane_np[g] > NP_W'(lo_q[g]))
			&& (lane_np[g] < NP_W'(hi_q[g])));
	end

	// stage 1: density rate times velocity step
	always_ff @(posedge clk) begin
		if (ld.ld_s1) begin
			dprod_s1 <= density_rate * $signed({1'b0, vstep});
			dens_s1  <= density;
			type_s1  <= material_type;
			last_s1  <= last_particle;
		end
	end

	// stage 2: round and add to density, clamp
	assign drnd = dprod_s1 + (DENS_PROD_W'(1) <<< (VEL_SHIFT - 1));
	assign dsum = DSUM_W'($signed(drnd[DENS_PROD_W-1:VEL_SHIFT])) + DSUM_W'(dens_s1);

	always_ff @(posedge clk) begin
		if (ld.ld_s2) begin
			dens_s2 <= mode_q[MODE_CONT] ? sat_dens(dsum) : dens_s1;
			type_s2 <= type_s1;
			last_s2 <= last_s1;
		end
	end

	// stages 3 and 4: side band follows the lanes
	always_ff @(posedge clk) begin
		if (ld.ld_s3) begin
			dens_s3 <= dens_s2;
			type_s3 <= type_s2;
			last_s3 <= last_s2;
		end
		if (ld.ld_s4) begin
			dens_s4 <= dens_s3;
			type_s4 <= type_s3;
			last_s4 <= last_s3;
		end
	end

	// stage 5: box decision and output register
	assign outside = !(&lane_in);
	assign drop    = lane_act[0] && mode_q[MODE_FIX] && outside;

	always_ff @(posedge clk) begin
		if (ld_s5) begin
			dens_s5    <= dens_s4;
			type_s5    <= drop ? NON_EXISTENT_CODE : type_s4;
			last_s5    <= last_s4;
			removed_s5 <= drop;
			for (int i = 0; i < NUM_COMP; i++) begin
				vel_s5[i*COMP_W +: COMP_W] <= lane_vel[i];
				if (!lane_act[i] || drop)
					pos_s5[i*COMP_W +: COMP_W] <= lane_pos[i];
				else if (mode_q[MODE_FIX])
					pos_s5[i*COMP_W +: COMP_W] <= lane_np[i][COMP_W-1:0];
				else
					pos_s5[i*COMP_W +: COMP_W] <= sat_comp(VSUM_W'(lane_np[i]));
			end
		end
	end

	assign out_valid         = vld_s5;
	assign new_density       = dens_s5;
	assign new_material_type = type_s5;
	assign new_velocity      = vel_s5;
	assign new_position      = pos_s5;
	assign removed           = removed_s5;
	assign last_out          = last_s5;

endmodule

FILE: hw/rtl/pis_checker.sv
`include "particle_integration_step_assert.svh"

module pis_checker import pis_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [DENS_W-1:0] new_density,
	input logic signed [TYPE_W-1:0] new_material_type,
	input logic [VEC_W-1:0]         new_velocity,
	input logic [VEC_W-1:0]         new_position,
	input logic                     removed,
	input logic                     last_out
);

	// a stalled result holds until its transaction completes
	`PIS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(new_density) && $stable(new_velocity) && $stable(new_position) && $stable(removed) && $stable(last_out), "output changed while stalled")

	// a removed particle carries the non-existent code
	`PIS_ASSERT_NOW(a_removed_code, out_valid && removed, new_material_type == NON_EXISTENT_CODE, "removed particle has wrong type")

	// a free output side never stalls the input
	`PIS_ASSERT_NOW(a_full_rate, out_ready || !out_valid, in_ready, "input stalled with output free")

endmodule

bind particle_integration_step pis_checker u_pis_checker (.*);

FILE: tb/particle_integration_step_checker.sv
`timescale 1ns / 1ps

// watches the configuration, particle and result channels, predicts each
// updated particle and compares it with what the block returns
module particle_integration_step_checker import pis_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [DENS_W-1:0]     density,
	input  logic [DENS_W-1:0]     density_rate,
	input  logic [TYPE_W-1:0]     material_type,
	input  logic [VEC_W-1:0]      velocity,
	input  logic [VEC_W-1:0]      acceleration,
	input  logic [VEC_W-1:0]      velocity_correction,
	input  logic [VEC_W-1:0]      position,
	input  logic                  last_particle,

	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [DENS_W-1:0]     new_density,
	input  logic [TYPE_W-1:0]     new_material_type,
	input  logic [VEC_W-1:0]      new_velocity,
	input  logic [VEC_W-1:0]      new_position,
	input  logic                  removed,
	input  logic                  last_out,

	output int                    mismatches,
	output int                    waiting
);

	localparam longint DENS_HI = (longint'(1) << (DENS_W - 1)) - 1;
	localparam longint DENS_LO = -(longint'(1) << (DENS_W - 1));
	localparam longint COMP_HI = (longint'(1) << (COMP_W - 1)) - 1;
	localparam longint COMP_LO = -(longint'(1) << (COMP_W - 1));

	typedef struct packed {
		logic [DENS_W-1:0] dens;
		logic [TYPE_W-1:0] mtype;
		logic [VEC_W-1:0]  vel;
		logic [VEC_W-1:0]  pos;
		logic              gone;
		logic              last;
	} particle_upd_t;

	// local copy of the block's registers
	logic [MODE_W-1:0]        mode_reg;
	logic [DT_W-1:0]          dt_reg;
	logic signed [COMP_W-1:0] lower [NUM_COMP];
	logic signed [COMP_W-1:0] upper [NUM_COMP];

	particle_upd_t updates_due [$];
	particle_upd_t want;
	int            fail_total = 0;

	assign mismatches = fail_total;

	// one line per mismatch
	task automatic report_mismatch(input string line);
		fail_total++;
		$display("%0t ns: %s", $time, line);
	endtask

	task automatic check_field(input string what, input logic [63:0] got,
			input logic [63:0] expd);
		if (got !== expd)
			report_mismatch($sformatf("%s got %h, expected %h", what, got, expd));
	endtask

	function automatic longint lane(input logic [VEC_W-1:0] vec, input int i);
		return longint'($signed(vec[i*COMP_W +: COMP_W]));
	endfunction

	// round to nearest, ties toward plus infinity
	function automatic longint round_shift(input longint v, input int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// leapfrog update of one particle under the current registers
	function automatic particle_upd_t advance_particle(
			input logic [DENS_W-1:0] rho_in, input logic [DENS_W-1:0] rate_in,
			input logic [TYPE_W-1:0] type_in, input logic [VEC_W-1:0] vel_in,
			input logic [VEC_W-1:0] acc_in, input logic [VEC_W-1:0] corr_in,
			input logic [VEC_W-1:0] pos_in, input logic last_in);
		particle_upd_t res;
		longint        dt_q;
		longint        vstep;
		longint        rho;
		longint        sum;
		longint        vel [NUM_COMP];
		longint        pos [NUM_COMP];
		longint        moved [NUM_COMP];
		int            axes;
		logic          in_box;
		dt_q = longint'(dt_reg);
		vstep = mode_reg[MODE_FIRST] ? dt_q : 2 * dt_q;
		rho = longint'($signed(rho_in));
		axes = mode_reg[MODE_THREE] ? NUM_COMP : 2;
		in_box = 1'b1;
		res.mtype = type_in;
		res.gone = 1'b0;
		res.last = last_in;
		for (int i = 0; i < NUM_COMP; i++) begin
			vel[i] = lane(vel_in, i);
			pos[i] = lane(pos_in, i);
			moved[i] = pos[i];
		end

		// density follows the continuity equation only when enabled
		if (mode_reg[MODE_CONT])
			rho = clamp(rho + round_shift(longint'($signed(rate_in)) * vstep, VEL_SHIFT),
				DENS_LO, DENS_HI);

		// only moving particles get kicked and drifted
		if ($signed(type_in) > 0) begin
			for (int i = 0; i < axes; i++) begin
				sum = vel[i] + round_shift(lane(acc_in, i) * vstep, VEL_SHIFT);
				if (mode_reg[MODE_AVG])
					sum += lane(corr_in, i);
				vel[i] = clamp(sum, COMP_LO, COMP_HI);
				moved[i] = pos[i] + round_shift(vel[i] * dt_q, POS_SHIFT);
				if (!(moved[i] < longint'(upper[i]) && moved[i] > longint'(lower[i])))
					in_box = 1'b0;
			end
			if (mode_reg[MODE_FIX]) begin
				if (in_box) begin
					for (int i = 0; i < axes; i++)
						pos[i] = moved[i];
				end else begin
					res.mtype = NON_EXISTENT_CODE;
					res.gone = 1'b1;
				end
			end else begin
				for (int i = 0; i < axes; i++)
					pos[i] = clamp(moved[i], COMP_LO, COMP_HI);
			end
		end

		res.dens = rho[DENS_W-1:0];
		for (int i = 0; i < NUM_COMP; i++) begin
			res.vel[i*COMP_W +: COMP_W] = vel[i][COMP_W-1:0];
			res.pos[i*COMP_W +: COMP_W] = pos[i][COMP_W-1:0];
		end
		return res;
	endfunction

	// channel monitor and comparison
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_reg <= '0;
			dt_reg <= DT_RESET;
			for (int i = 0; i < NUM_COMP; i++) begin
				lower[i] <= $signed(COMP_MIN);
				upper[i] <= $signed(COMP_MAX);
			end
			updates_due.delete();
			waiting <= 0;
		end else begin
			// result transaction against the oldest prediction
			if (out_valid && out_ready) begin
				if (updates_due.size() == 0) begin
					report_mismatch("result transaction with no particle outstanding");
				end else begin
					want = updates_due.pop_front();
					check_field("new_density", 64'(new_density), 64'(want.dens));
					check_field("new_material_type", 64'(new_material_type),
						64'(want.mtype));
					check_field("new_velocity", 64'(new_velocity), 64'(want.vel));
					check_field("new_position", 64'(new_position), 64'(want.pos));
					check_field("removed", 64'(removed), 64'(want.gone));
					check_field("last_out", 64'(last_out), 64'(want.last));
				end
			end

			// particle transaction
			if (in_valid && in_ready)
				updates_due.push_back(advance_particle(density, density_rate,
					material_type, velocity, acceleration, velocity_correction,
					position, last_particle));

			// register write, masked to the register width
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				REG_MODE_FLAGS: mode_reg <= cfg_data[MODE_W-1:0];
				REG_TIME_STEP:  dt_reg <= cfg_data[DT_W-1:0];
				REG_X_LOWER:    lower[0] <= cfg_data[COMP_W-1:0];
				REG_X_UPPER:    upper[0] <= cfg_data[COMP_W-1:0];
				REG_Y_LOWER:    lower[1] <= cfg_data[COMP_W-1:0];
				REG_Y_UPPER:    upper[1] <= cfg_data[COMP_W-1:0];
				REG_Z_LOWER:    lower[2] <= cfg_data[COMP_W-1:0];
				REG_Z_UPPER:    upper[2] <= cfg_data[COMP_W-1:0];
				default: ;
				endcase
			end

			waiting <= updates_due.size();
		end
	end

endmodule

FILE: tb/particle_integration_step_tb.sv
`timescale 1ns / 1ps

module particle_integration_step_tb;
	import pis_pkg::*;

	localparam int NUM_REGS   = 8;
	localparam int LATENCY    = 5;
	localparam int SEGMENTS   = 8;
	localparam int SEG_ITEMS  = 100;
	localparam int TIMEOUT_NS = 1_000_000;
	localparam int MAXC       = 1048575;
	localparam int MINC       = -1048576;

	typedef struct packed {
		logic [DENS_W-1:0] rho;
		logic [DENS_W-1:0] rate;
		logic [TYPE_W-1:0] mtype;
		logic [VEC_W-1:0]  vel;
		logic [VEC_W-1:0]  acc;
		logic [VEC_W-1:0]  corr;
		logic [VEC_W-1:0]  pos;
		logic              last;
	} particle_in_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]    cfg_data;
	logic                     in_valid;
	logic                     in_ready;
	logic signed [DENS_W-1:0] density;
	logic signed [DENS_W-1:0] density_rate;
	logic signed [TYPE_W-1:0] material_type;
	logic [VEC_W-1:0]         velocity;
	logic [VEC_W-1:0]         acceleration;
	logic [VEC_W-1:0]         velocity_correction;
	logic [VEC_W-1:0]         position;
	logic                     last_particle;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [DENS_W-1:0] new_density;
	logic signed [TYPE_W-1:0] new_material_type;
	logic [VEC_W-1:0]         new_velocity;
	logic [VEC_W-1:0]         new_position;
	logic                     removed;
	logic                     last_out;
	int                       mismatches;
	int                       waiting;

	int send_gap_pct = 12;
	int recv_stall_pct = 78;

	always #1 clk = ~clk;

	particle_integration_step dut (.*);

	particle_integration_step_checker chk (.*);

	// receiver back-pressure
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	function automatic logic [VEC_W-1:0] vec3(input int x, input int y, input int z);
		return {COMP_W'(z), COMP_W'(y), COMP_W'(x)};
	endfunction

	function automatic particle_in_t particle(input logic [DENS_W-1:0] rho,
			input logic [DENS_W-1:0] rate, input logic [TYPE_W-1:0] mtype,
			input logic [VEC_W-1:0] vel, input logic [VEC_W-1:0] acc,
			input logic [VEC_W-1:0] corr, input logic [VEC_W-1:0] pos, input logic last);
		particle_in_t p;
		p.rho = rho;
		p.rate = rate;
		p.mtype = mtype;
		p.vel = vel;
		p.acc = acc;
		p.corr = corr;
		p.pos = pos;
		p.last = last;
		return p;
	endfunction

	// modest values half the time, with extremes and full-range noise mixed in
	function automatic logic [COMP_W-1:0] rand_comp(input int spread);
		case ($urandom_range(9))
		0: return COMP_MAX;
		1: return COMP_MIN;
		2, 3, 4: return COMP_W'($urandom);
		default: return COMP_W'(int'($urandom_range(0, 2 * spread)) - spread);
		endcase
	endfunction

	function automatic logic [VEC_W-1:0] rand_vec(input int spread);
		return {rand_comp(spread), rand_comp(spread), rand_comp(spread)};
	endfunction

	function automatic logic [DENS_W-1:0] rand_dens();
		if ($urandom_range(2) == 0)
			return DENS_W'($urandom);
		return DENS_W'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
	endfunction

	function automatic particle_in_t rand_particle();
		particle_in_t p;
		int           pick;
		pick = $urandom_range(9);
		p.rho = rand_dens();
		p.rate = rand_dens();
		if (pick < 7)
			p.mtype = TYPE_W'($urandom_range(1, 127));
		else if (pick < 9)
			p.mtype = TYPE_W'(-int'($urandom_range(128)));
		else
			p.mtype = TYPE_W'($urandom);
		p.vel = rand_vec(1024);
		p.acc = rand_vec(2048);
		p.corr = rand_vec(512);
		p.pos = rand_vec(1 << 17);
		p.last = ($urandom_range(7) == 0);
		return p;
	endfunction

	// box per axis: whole range, wide, narrow or arbitrary (possibly inverted)
	task automatic pick_bounds(output logic [VEC_W-1:0] lo, output logic [VEC_W-1:0] hi);
		for (int i = 0; i < NUM_COMP; i++) begin
			case ($urandom_range(3))
			0: begin
				lo[i*COMP_W +: COMP_W] = COMP_MIN;
				hi[i*COMP_W +: COMP_W] = COMP_MAX;
			end
			1: begin
				lo[i*COMP_W +: COMP_W] = COMP_W'(-int'($urandom_range(1, 1 << 20)));
				hi[i*COMP_W +: COMP_W] = COMP_W'($urandom_range(1, (1 << 20) - 1));
			end
			2: begin
				lo[i*COMP_W +: COMP_W] = COMP_W'(-int'($urandom_range(1, 1 << 12)));
				hi[i*COMP_W +: COMP_W] = COMP_W'($urandom_range(1, 1 << 12));
			end
			default: begin
				lo[i*COMP_W +: COMP_W] = COMP_W'($urandom);
				hi[i*COMP_W +: COMP_W] = COMP_W'($urandom);
			end
			endcase
		end
	endtask

	// write every register, junk in the unused upper bits, then one stray index
	task automatic program_regs(input logic [MODE_W-1:0] mode, input logic [DT_W-1:0] dt,
			input logic [VEC_W-1:0] lo, input logic [VEC_W-1:0] hi);
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
		for (int k = 0; k <= NUM_REGS; k++) begin
			if (k < NUM_REGS)
				idx = CFG_IDX_W'(k);
			else
				idx = CFG_IDX_W'(NUM_REGS + $urandom_range(NUM_REGS - 1));
			case (idx)
			REG_MODE_FLAGS: val = {(CFG_DATA_W-MODE_W)'($urandom), mode};
			REG_TIME_STEP:  val = dt;
			REG_X_LOWER:    val = {(CFG_DATA_W-COMP_W)'($urandom), lo[0 +: COMP_W]};
			REG_X_UPPER:    val = {(CFG_DATA_W-COMP_W)'($urandom), hi[0 +: COMP_W]};
			REG_Y_LOWER:    val = {(CFG_DATA_W-COMP_W)'($urandom), lo[COMP_W +: COMP_W]};
			REG_Y_UPPER:    val = {(CFG_DATA_W-COMP_W)'($urandom), hi[COMP_W +: COMP_W]};
			REG_Z_LOWER:    val = {(CFG_DATA_W-COMP_W)'($urandom), lo[2*COMP_W +: COMP_W]};
			REG_Z_UPPER:    val = {(CFG_DATA_W-COMP_W)'($urandom), hi[2*COMP_W +: COMP_W]};
			default:        val = CFG_DATA_W'($urandom);
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= val;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// one particle transaction, with random gaps ahead of it
	task automatic send_particle(input particle_in_t p);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		density <= p.rho;
		density_rate <= p.rate;
		material_type <= p.mtype;
		velocity <= p.vel;
		acceleration <= p.acc;
		velocity_correction <= p.corr;
		position <= p.pos;
		last_particle <= p.last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// hold off until every outstanding particle has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
	endtask

	// run limit
	initial begin
		#TIMEOUT_NS;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// stimulus and verdict
	initial begin
		logic [MODE_W-1:0] mode;
		logic [DT_W-1:0]   dt;
		logic [VEC_W-1:0]  lo;
		logic [VEC_W-1:0]  hi;
		logic [VEC_W-1:0]  full_lo;
		logic [VEC_W-1:0]  full_hi;
		full_lo = {NUM_COMP{COMP_MIN}};
		full_hi = {NUM_COMP{COMP_MAX}};
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		density = '0;
		density_rate = '0;
		material_type = '0;
		velocity = '0;
		acceleration = '0;
		velocity_correction = '0;
		position = '0;
		last_particle = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values: two-d, no continuity, no fix
		send_particle(particle(32'h0001_0000, 32'h7fff_ffff, 8'sd3, vec3(1024, -1024, 7),
			vec3(300, -300, 5), vec3(9, 9, 9), vec3(0, 0, 0), 1'b0));
		send_particle(particle(32'h8000_0000, 32'h8000_0000, -8'sd2, vec3(5, 5, 5),
			vec3(5, 5, 5), vec3(5, 5, 5), vec3(MAXC, MINC, 0), 1'b1));
		wait_drained();

		// every mode on, largest step, box of plus or minus 100
		program_regs({MODE_W{1'b1}}, {DT_W{1'b1}}, vec3(-102400, -102400, -102400),
			vec3(102400, 102400, 102400));
		send_particle(particle(32'h7fff_ffff, 32'h7fff_ffff, 8'sd127, vec3(MAXC, MAXC, MAXC),
			vec3(MAXC, MAXC, MAXC), vec3(MAXC, MAXC, MAXC), vec3(0, 0, 0), 1'b1));
		send_particle(particle(32'h8000_0000, 32'h8000_0000, -8'sd128, vec3(MINC, MINC, MINC),
			vec3(MINC, MINC, MINC), vec3(MINC, MINC, MINC), vec3(MINC, MINC, MINC), 1'b0));
		send_particle(particle(32'h0002_0000, 32'hffff_0000, 8'sd1, vec3(100, -100, 50),
			vec3(10, -10, 0), vec3(0, 0, 0), vec3(0, 0, 0), 1'b0));
		send_particle(particle(32'h0002_0000, 32'h0000_4000, 8'sd1, vec3(1024, 0, 0),
			vec3(0, 0, 0), vec3(0, 0, 0), vec3(102000, 0, 0), 1'b0));
		send_particle(particle(32'h0002_0000, 32'h0000_4000, 8'sd1, vec3(0, 0, -1024),
			vec3(0, 0, 0), vec3(0, 0, 0), vec3(0, 0, -102000), 1'b0));
		send_particle(particle(32'h0010_0000, 32'h0003_0000, 8'sd0, vec3(77, -77, 77),
			vec3(500, 500, 500), vec3(3, 3, 3), vec3(10, 20, 30), 1'b1));
		wait_drained();

		// zero step, two-d with fix: a position on the open bound is out
		program_regs(MODE_W'((1 << MODE_FIX) | (1 << MODE_AVG)), '0, full_lo, full_hi);
		send_particle(particle(32'h0001_0000, 32'h0001_0000, 8'sd5, vec3(200, 200, 200),
			vec3(MAXC, MAXC, MAXC), vec3(-50, 60, 70), vec3(MAXC, 0, 0), 1'b0));
		send_particle(particle(32'h0001_0000, 32'h0001_0000, 8'sd5, vec3(0, 0, MAXC),
			vec3(0, 0, 0), vec3(1, 1, MAXC), vec3(0, 0, MINC), 1'b0));
		send_particle(particle(32'h0001_0000, 32'h0001_0000, 8'sd5, vec3(0, 0, 0),
			vec3(0, 0, 0), vec3(0, 0, 0), vec3(MINC + 1, MINC + 1, 0), 1'b1));
		wait_drained();

		// smallest step, continuity, three-d, no fix: position saturation, rounding ties
		program_regs(MODE_W'((1 << MODE_CONT) | (1 << MODE_THREE)), DT_W'(1),
			vec3(1000, 1000, 1000), vec3(-1000, -1000, -1000));
		send_particle(particle(32'h0000_0000, 32'h0000_0000, 8'sd9, vec3(MAXC, MAXC, MAXC),
			vec3(0, 0, 0), vec3(0, 0, 0), vec3(MAXC, MAXC, MAXC), 1'b0));
		send_particle(particle(32'h0000_0000, 32'h0000_0000, 8'sd9, vec3(MINC, MINC, MINC),
			vec3(0, 0, 0), vec3(0, 0, 0), vec3(MINC, MINC, MINC), 1'b0));
		send_particle(particle(32'h0000_1000, 32'h0008_0000, -8'sd1, vec3(0, 0, 0),
			vec3(0, 0, 0), vec3(0, 0, 0), vec3(0, 0, 0), 1'b0));
		send_particle(particle(32'h0000_1000, 32'hfff8_0000, 8'sd1, vec3(0, 0, 0),
			vec3(524288, -524288, 1), vec3(0, 0, 0), vec3(0, 0, 0), 1'b1));
		wait_drained();

		// first step only: correction must be ignored
		program_regs(MODE_W'(1 << MODE_FIRST), DT_RESET, full_lo, full_hi);
		send_particle(particle(32'h0001_0000, 32'h0001_0000, 8'sd2, vec3(1024, 2048, -1024),
			vec3(4096, -4096, 100), vec3(MAXC, MINC, MAXC), vec3(5000, -5000, 0), 1'b1));
		send_particle(particle(32'h0001_0000, 32'h0001_0000, -8'sd1, vec3(1024, 2048, -1024),
			vec3(4096, -4096, 100), vec3(MAXC, MINC, MAXC), vec3(5000, -5000, 0), 1'b1));

		// random segments, each under its own register setting
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			wait_drained();
			if (seg < 3) begin
				send_gap_pct = 12;
				recv_stall_pct = 78;
			end else if (seg < 6) begin
				send_gap_pct = 78;
				recv_stall_pct = 12;
			end else begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end
			if (seg == 0)
				mode = '0;
			else if (seg == 1)
				mode = {MODE_W{1'b1}};
			else
				mode = MODE_W'($urandom_range(31));
			if (seg == 2)
				dt = DT_W'(1);
			else if (seg == 3)
				dt = {DT_W{1'b1}};
			else if ($urandom_range(1) == 0)
				dt = DT_W'($urandom);
			else
				dt = DT_W'($urandom_range(1, 1 << 16));
			if (seg == 0) begin
				lo = full_lo;
				hi = full_hi;
			end else begin
				pick_bounds(lo, hi);
			end
			program_regs(mode, dt, lo, hi);
			for (int n = 0; n < SEG_ITEMS; n++) begin
				// sender holds back until the pipeline has emptied
				if (seg == 4 && n == SEG_ITEMS / 2)
					wait_drained();
				send_particle(rand_particle());
			end
		end

		wait_drained();
		repeat (2 * LATENCY) @(posedge clk);
		if (mismatches == 0 && waiting == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/pis_pkg.sv
hw/rtl/pis_lane.sv
hw/rtl/particle_integration_step.sv
hw/rtl/pis_checker.sv
tb/particle_integration_step_checker.sv
tb/particle_integration_step_tb.sv
